FILE: hw/rtl/pbc_pkg.sv
// ----------------------------------------------------------------------------
// pbc_pkg
// Shared types, constants, codes and helpers of the predicated byte CPU.
// ----------------------------------------------------------------------------
package pbc_pkg;

  localparam int unsigned REG_SELECT_BITS = 8;
  localparam int unsigned MEM_ADDR_BITS   = 12;
  localparam int unsigned REG_COUNT       = 1 << REG_SELECT_BITS;
  localparam int unsigned FIELD_COUNT     = 5;

  // Instruction word: predicated bit, predicate register, class, function, operands.
  localparam int unsigned INSN_W      = 1 + REG_SELECT_BITS + 2 + 6 + FIELD_COUNT * REG_SELECT_BITS;
  localparam int unsigned IN_TDATA_W  = ((INSN_W + 7) / 8) * 8;
  localparam int unsigned FUNC_LSB    = REG_SELECT_BITS + 3;
  localparam int unsigned RES_W       = 32 + 1 + 8 + 1 + 32 + 1 + 1;
  localparam int unsigned OUT_TDATA_W = ((RES_W + 7) / 8) * 8;

  typedef enum logic [1:0] {
    CLS_MEM   = 2'd0,
    CLS_ALU   = 2'd1,
    CLS_CTL   = 2'd2,
    CLS_UNDEF = 2'd3
  } pbc_cls_e;

  // Memory class functions
  localparam logic [5:0] MEM_LD_REG = 6'd0;
  localparam logic [5:0] MEM_LD_IMM = 6'd1;
  localparam logic [5:0] MEM_ST_REG = 6'd2;
  localparam logic [5:0] MEM_ST_IMM = 6'd3;

  // ALU class functions
  localparam logic [5:0] ALU_MOV_IMM  = 6'd0;
  localparam logic [5:0] ALU_MOV_REG  = 6'd1;
  localparam logic [5:0] ALU_ADD_IMM  = 6'd2;
  localparam logic [5:0] ALU_ADD_REG  = 6'd3;
  localparam logic [5:0] ALU_ADDC_IMM = 6'd4;
  localparam logic [5:0] ALU_ADDC_REG = 6'd5;
  localparam logic [5:0] ALU_MUL_IMM  = 6'd6;
  localparam logic [5:0] ALU_MUL_REG  = 6'd7;
  localparam logic [5:0] ALU_MULH_IMM = 6'd8;
  localparam logic [5:0] ALU_MULH_REG = 6'd9;
  localparam logic [5:0] ALU_DIV_IR   = 6'd10;
  localparam logic [5:0] ALU_DIV_RI   = 6'd11;
  localparam logic [5:0] ALU_DIV_RR   = 6'd12;
  localparam logic [5:0] ALU_MOD_IR   = 6'd13;
  localparam logic [5:0] ALU_MOD_RI   = 6'd14;
  localparam logic [5:0] ALU_MOD_RR   = 6'd15;
  localparam logic [5:0] ALU_AND_IMM  = 6'd16;
  localparam logic [5:0] ALU_AND_REG  = 6'd17;
  localparam logic [5:0] ALU_OR_IMM   = 6'd18;
  localparam logic [5:0] ALU_OR_REG   = 6'd19;
  localparam logic [5:0] ALU_XOR_IMM  = 6'd20;
  localparam logic [5:0] ALU_XOR_REG  = 6'd21;
  localparam logic [5:0] ALU_NOT      = 6'd22;

  // Control class functions
  localparam logic [5:0] CTL_JF_IMM   = 6'd0;
  localparam logic [5:0] CTL_JF_REG   = 6'd1;
  localparam logic [5:0] CTL_JB_IMM   = 6'd2;
  localparam logic [5:0] CTL_JB_REG   = 6'd3;
  localparam logic [5:0] CTL_HALT_IMM = 6'd4;
  localparam logic [5:0] CTL_HALT_REG = 6'd5;
  localparam logic [5:0] CTL_SP_IMM   = 6'd6;
  localparam logic [5:0] CTL_SP_REG   = 6'd7;
  localparam logic [5:0] CTL_PUSH_REG = 6'd8;
  localparam logic [5:0] CTL_PUSH_IMM = 6'd9;
  localparam logic [5:0] CTL_POP      = 6'd10;
  localparam logic [5:0] CTL_PRINT_A  = 6'd11;
  localparam logic [5:0] CTL_PRINT_B  = 6'd12;
  localparam logic [5:0] CTL_HANDLER  = 6'd13;
  localparam logic [5:0] CTL_REASON   = 6'd14;

  typedef struct packed {
    logic                                             pred;
    logic [REG_SELECT_BITS-1:0]                       pred_reg;
    pbc_cls_e                                         cls;
    logic [5:0]                                       func;
    logic [FIELD_COUNT-1:0][REG_SELECT_BITS-1:0]      v;
    logic                                             bad;
  } pbc_item_t;

  typedef struct packed {
    logic        bad_opcode;
    logic        divide_by_zero;
    logic [31:0] halt_code;
    logic        halted;
    logic [7:0]  print_char;
    logic        print_valid;
    logic [31:0] next_pc;
  } pbc_result_t;

  function automatic logic [31:0] quad(input logic [7:0] a, input logic [7:0] b,
                                       input logic [7:0] c, input logic [7:0] d);
    quad = {a, b, c, d};
  endfunction

endpackage

FILE: hw/rtl/pbc_front.sv
// ----------------------------------------------------------------------------
// pbc_front
// Accept instruction words, split them into fields, flag undefined codes and
// hold them in a two-entry queue for the execute side.
// ----------------------------------------------------------------------------
module pbc_front (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               block_i,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [pbc_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  output pbc_pkg::pbc_item_t                 head_o,
  output logic                               head_valid_o,
  input  logic                               pop_i
);
  import pbc_pkg::*;

  logic [INSN_W-1:0]                        word;
  logic [INSN_W-FUNC_LSB-1:0]               args;
  logic [FIELD_COUNT*REG_SELECT_BITS-1:0]   ops;
  pbc_item_t                                dec;
  pbc_item_t                                slot_q [2];
  logic                                     wr_ptr_q, rd_ptr_q;
  logic [1:0]                               count_q;
  logic                                     push;

  assign word = s_axis_tdata[INSN_W-1:0];
  assign args = word[INSN_W-1:FUNC_LSB];

  always_comb begin
    dec          = '0;
    dec.pred     = word[0];
    dec.pred_reg = word[REG_SELECT_BITS:1];
    dec.cls      = pbc_cls_e'(word[REG_SELECT_BITS+2:REG_SELECT_BITS+1]);
    ops          = '0;
    unique case (dec.cls)
      CLS_MEM: begin
        dec.func = {4'd0, args[1:0]};
        ops      = args[2 +: FIELD_COUNT*REG_SELECT_BITS];
        dec.bad  = 1'b0;
      end
      CLS_ALU: begin
        dec.func = args[5:0];
        ops      = args[6 +: FIELD_COUNT*REG_SELECT_BITS];
        dec.bad  = (args[5:0] > ALU_NOT);
      end
      CLS_CTL: begin
        dec.func = {1'b0, args[4:0]};
        ops      = args[5 +: FIELD_COUNT*REG_SELECT_BITS];
        dec.bad  = ({1'b0, args[4:0]} > CTL_REASON);
      end
      default: begin
        dec.bad  = 1'b1;
      end
    endcase
    dec.v = ops;
  end

  assign s_axis_tready = (count_q != 2'd2) && !block_i;
  assign push          = s_axis_tvalid && s_axis_tready;
  assign head_o        = slot_q[rd_ptr_q];
  assign head_valid_o  = (count_q != 2'd0);

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= dec;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      count_q <= count_q + {1'b0, push} - {1'b0, pop_i};
    end
  end

endmodule

FILE: hw/rtl/pbc_exec.sv
// ----------------------------------------------------------------------------
// pbc_exec
// Execute sequencer: register file, data memory, bit-serial divider, stack
// engine and the result register.
// ----------------------------------------------------------------------------
module pbc_exec #(
  parameter int unsigned MemAddrBits = pbc_pkg::MEM_ADDR_BITS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  pbc_pkg::pbc_item_t   item_i,
  input  logic                 item_valid_i,
  output logic                 item_pop_o,
  output logic                 clearing_o,
  input  logic [7:0]           fault_reason_i,
  output pbc_pkg::pbc_result_t res_o,
  output logic                 res_valid_o,
  input  logic                 res_ready_i
);
  import pbc_pkg::*;

  localparam int unsigned MemDepth = 1 << MemAddrBits;

  localparam logic [3:0] ST_CLEAR = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_READ  = 4'd2;
  localparam logic [3:0] ST_EXEC  = 4'd3;
  localparam logic [3:0] ST_MEMRD = 4'd4;
  localparam logic [3:0] ST_WR2   = 4'd5;
  localparam logic [3:0] ST_DIV   = 4'd6;
  localparam logic [3:0] ST_DIVWR = 4'd7;
  localparam logic [3:0] ST_PUSH  = 4'd8;
  localparam logic [3:0] ST_POP   = 4'd9;
  localparam logic [3:0] ST_DONE  = 4'd10;

  logic [7:0] mem [MemDepth];
  logic [7:0] rf  [REG_COUNT];

  logic                        mem_we;
  logic [MemAddrBits-1:0]      mem_waddr, mem_raddr;
  logic [7:0]                  mem_wdata, mem_rdata_q;
  logic                        rf_we;
  logic [REG_SELECT_BITS-1:0]  rf_waddr, rf_raddr;
  logic [7:0]                  rf_wdata, rf_rdata_q;

  logic [3:0]             state_q;
  logic [MemAddrBits-1:0] clr_q;
  logic [2:0]             k_q;
  pbc_item_t              item_q;
  logic [7:0]             rv_q [FIELD_COUNT];
  logic [31:0]            next_q, pc_q, sp_q, halt_val_q;
  logic                   halt_q, pv_q, dz_q, bad_q, res_valid_q;
  logic [7:0]             pch_q, r2_q;
  pbc_result_t            res_q;
  logic [7:0]             dv_quo_q, dv_rem_q, dv_b_q;
  logic [2:0]             dv_cnt_q;
  logic                   dv_mod_q;

  logic [7:0]  fb [FIELD_COUNT];
  logic [31:0] fquad, rquad, maddr;
  logic [7:0]  r1, r2, div_a, div_b;
  logic        has_r2, is_div, is_mod;
  logic [8:0]  sum9;
  logic [15:0] prod;
  logic [8:0]  dv_try;
  logic [2:0]  push_start;
  logic [7:0]  push_val;
  logic [2:0]  seq_idx;

  always_comb begin
    for (int i = 0; i < FIELD_COUNT; i++) begin
      fb[i] = 8'(item_q.v[i]);
    end
  end

  assign fquad = quad(fb[0], fb[1], fb[2], fb[3]);
  assign rquad = quad(rv_q[0], rv_q[1], rv_q[2], rv_q[3]);
  assign maddr = item_q.func[0] ? fquad : rquad;

  // ALU datapath
  always_comb begin
    r1     = '0;
    r2     = '0;
    has_r2 = 1'b0;
    is_div = 1'b0;
    is_mod = 1'b0;
    div_a  = rv_q[1];
    div_b  = rv_q[2];
    sum9   = {1'b0, rv_q[2]} + {1'b0, (item_q.func == ALU_ADDC_IMM) ? fb[3] : rv_q[3]};
    prod   = 16'(rv_q[3]) * 16'((item_q.func == ALU_MULH_IMM) ? fb[2] : rv_q[2]);
    unique case (item_q.func)
      ALU_MOV_IMM: r1 = fb[1];
      ALU_MOV_REG: r1 = rv_q[1];
      ALU_ADD_IMM: r1 = rv_q[1] + fb[2];
      ALU_ADD_REG: r1 = rv_q[1] + rv_q[2];
      ALU_ADDC_IMM, ALU_ADDC_REG: begin
        r1     = sum9[7:0];
        r2     = {7'd0, sum9[8]};
        has_r2 = 1'b1;
      end
      ALU_MUL_IMM: r1 = 8'(rv_q[1] * fb[2]);
      ALU_MUL_REG: r1 = 8'(rv_q[1] * rv_q[2]);
      ALU_MULH_IMM, ALU_MULH_REG: begin
        r1     = prod[7:0];
        r2     = prod[15:8];
        has_r2 = 1'b1;
      end
      ALU_DIV_IR, ALU_MOD_IR: begin
        is_div = 1'b1;
        div_a  = fb[1];
      end
      ALU_DIV_RI, ALU_MOD_RI: begin
        is_div = 1'b1;
        div_b  = fb[2];
      end
      ALU_DIV_RR, ALU_MOD_RR: is_div = 1'b1;
      ALU_AND_IMM: r1 = rv_q[1] & fb[2];
      ALU_AND_REG: r1 = rv_q[1] & rv_q[2];
      ALU_OR_IMM:  r1 = rv_q[1] | fb[2];
      ALU_OR_REG:  r1 = rv_q[1] | rv_q[2];
      ALU_XOR_IMM: r1 = rv_q[1] ^ fb[2];
      ALU_XOR_REG: r1 = rv_q[1] ^ rv_q[2];
      default:     r1 = ~rv_q[1];
    endcase
    is_mod = (item_q.func >= ALU_MOD_IR);
  end

  assign dv_try = {dv_rem_q, dv_quo_q[7]};

  // Push frame: leading v1 (register form only), then a tail of v2,v3,v4,v5,v1
  always_comb begin
    if (item_q.v[0] == '0) begin
      push_start = 3'd4;
    end else if (fb[0] >= 8'd4) begin
      push_start = 3'd3;
    end else begin
      push_start = 3'(fb[0] - 8'd1);
    end
    seq_idx  = (k_q == 3'd4) ? 3'd0 : 3'(k_q + 3'd1);
    push_val = (item_q.func == CTL_PUSH_REG) ? rv_q[seq_idx] : fb[seq_idx];
  end

  // Memory and register file ports
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = sp_q[MemAddrBits-1:0];
    mem_wdata = rv_q[0];
    mem_raddr = maddr[MemAddrBits-1:0];
    rf_we     = 1'b0;
    rf_waddr  = item_q.v[0];
    rf_wdata  = r1;
    rf_raddr  = item_i.pred_reg;
    unique case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
        rf_we     = 1'b1;
        rf_waddr  = clr_q[REG_SELECT_BITS-1:0];
        rf_wdata  = '0;
      end
      ST_READ: begin
        rf_raddr = (k_q < 3'd5) ? item_q.v[k_q] : '0;
      end
      ST_EXEC: begin
        unique case (item_q.cls)
          CLS_MEM: begin
            mem_we    = item_q.func[1];
            mem_waddr = maddr[MemAddrBits-1:0];
            mem_wdata = rv_q[4];
          end
          CLS_ALU: begin
            rf_we    = 1'b1;
            rf_wdata = (is_div && div_b == '0) ? 8'd0 : r1;
            rf_we    = !(is_div && div_b != '0);
          end
          CLS_CTL: begin
            mem_raddr = MemAddrBits'(sp_q - 32'd1);
            mem_we    = (item_q.func == CTL_PUSH_REG);
            rf_we     = (item_q.func == CTL_REASON);
            rf_wdata  = fault_reason_i;
          end
          default: begin
            rf_we = 1'b0;
          end
        endcase
      end
      ST_MEMRD: begin
        rf_we    = 1'b1;
        rf_waddr = item_q.v[4];
        rf_wdata = mem_rdata_q;
      end
      ST_WR2: begin
        rf_we    = 1'b1;
        rf_waddr = item_q.v[1];
        rf_wdata = r2_q;
      end
      ST_DIVWR: begin
        rf_we    = 1'b1;
        rf_wdata = dv_mod_q ? dv_rem_q : dv_quo_q;
      end
      ST_PUSH: begin
        mem_we    = 1'b1;
        mem_wdata = push_val;
      end
      default: begin
        rf_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata_q <= mem[mem_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (rf_we) begin
      rf[rf_waddr] <= rf_wdata;
    end
    rf_rdata_q <= rf[rf_raddr];
  end

  assign item_pop_o  = (state_q == ST_IDLE) && item_valid_i && !res_valid_q;
  assign clearing_o  = (state_q == ST_CLEAR);
  assign res_o       = res_q;
  assign res_valid_o = res_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      k_q         <= '0;
      item_q      <= '0;
      for (int i = 0; i < FIELD_COUNT; i++) begin
        rv_q[i] <= '0;
      end
      next_q      <= '0;
      pc_q        <= '0;
      sp_q        <= '0;
      halt_val_q  <= '0;
      halt_q      <= 1'b0;
      pv_q        <= 1'b0;
      dz_q        <= 1'b0;
      bad_q       <= 1'b0;
      pch_q       <= '0;
      r2_q        <= '0;
      res_q       <= '0;
      res_valid_q <= 1'b0;
      dv_quo_q    <= '0;
      dv_rem_q    <= '0;
      dv_b_q      <= '0;
      dv_cnt_q    <= '0;
      dv_mod_q    <= 1'b0;
    end else begin
      if (res_valid_q && res_ready_i) begin
        res_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + MemAddrBits'(1);
          if (clr_q == '1) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (item_pop_o) begin
            item_q <= item_i;
            pv_q   <= 1'b0;
            pch_q  <= '0;
            dz_q   <= 1'b0;
            bad_q  <= 1'b0;
            k_q    <= '0;
            if (halt_q) begin
              next_q  <= pc_q;
              state_q <= ST_DONE;
            end else begin
              next_q  <= pc_q + 32'd8;
              state_q <= ST_READ;
            end
          end
        end
        ST_READ: begin
          if (k_q == 3'd0 && item_q.pred && rf_rdata_q == '0) begin
            state_q <= ST_DONE;
          end else begin
            if (k_q != 3'd0) begin
              rv_q[3'(k_q - 3'd1)] <= rf_rdata_q;
            end
            k_q <= k_q + 3'd1;
            if (k_q == 3'd5) begin
              if (item_q.bad) begin
                bad_q   <= 1'b1;
                state_q <= ST_DONE;
              end else begin
                state_q <= ST_EXEC;
              end
            end
          end
        end
        ST_EXEC: begin
          state_q <= ST_DONE;
          unique case (item_q.cls)
            CLS_MEM: begin
              if (!item_q.func[1]) begin
                state_q <= ST_MEMRD;
              end
            end
            CLS_ALU: begin
              if (is_div) begin
                if (div_b == '0) begin
                  dz_q <= 1'b1;
                end else begin
                  dv_quo_q <= div_a;
                  dv_rem_q <= '0;
                  dv_b_q   <= div_b;
                  dv_cnt_q <= '0;
                  dv_mod_q <= is_mod;
                  state_q  <= ST_DIV;
                end
              end else if (has_r2) begin
                r2_q    <= r2;
                state_q <= ST_WR2;
              end
            end
            CLS_CTL: begin
              unique case (item_q.func)
                CTL_JF_IMM: next_q <= pc_q + fquad;
                CTL_JF_REG: next_q <= pc_q + rquad;
                CTL_JB_IMM: next_q <= pc_q - fquad;
                CTL_JB_REG: next_q <= pc_q - rquad;
                CTL_HALT_IMM, CTL_HALT_REG: begin
                  halt_q     <= 1'b1;
                  halt_val_q <= (item_q.func == CTL_HALT_IMM) ? fquad : rquad;
                  next_q     <= pc_q;
                end
                CTL_SP_IMM: sp_q <= fquad;
                CTL_SP_REG: sp_q <= rquad;
                CTL_PUSH_REG: begin
                  sp_q    <= sp_q + 32'd1;
                  k_q     <= push_start;
                  state_q <= ST_PUSH;
                end
                CTL_PUSH_IMM: begin
                  k_q     <= push_start;
                  state_q <= ST_PUSH;
                end
                CTL_POP: begin
                  sp_q    <= sp_q - 32'd1;
                  state_q <= ST_POP;
                end
                CTL_PRINT_A, CTL_PRINT_B: begin
                  pv_q  <= 1'b1;
                  pch_q <= rv_q[0];
                end
                default: begin
                  pv_q <= 1'b0;
                end
              endcase
            end
            default: begin
              bad_q <= 1'b1;
            end
          endcase
        end
        ST_MEMRD: state_q <= ST_DONE;
        ST_WR2:   state_q <= ST_DONE;
        ST_DIV: begin
          if (dv_try >= {1'b0, dv_b_q}) begin
            dv_rem_q <= 8'(dv_try - {1'b0, dv_b_q});
            dv_quo_q <= {dv_quo_q[6:0], 1'b1};
          end else begin
            dv_rem_q <= dv_try[7:0];
            dv_quo_q <= {dv_quo_q[6:0], 1'b0};
          end
          dv_cnt_q <= dv_cnt_q + 3'd1;
          if (dv_cnt_q == 3'd7) begin
            state_q <= ST_DIVWR;
          end
        end
        ST_DIVWR: state_q <= ST_DONE;
        ST_PUSH: begin
          sp_q <= sp_q + 32'd1;
          k_q  <= k_q + 3'd1;
          if (k_q == 3'd4) begin
            state_q <= ST_DONE;
          end
        end
        ST_POP: begin
          sp_q    <= sp_q - ((mem_rdata_q >= 8'd4) ? 32'd4 : 32'(mem_rdata_q));
          state_q <= ST_DONE;
        end
        ST_DONE: begin
          res_q.next_pc        <= next_q;
          res_q.print_valid    <= pv_q;
          res_q.print_char     <= pch_q;
          res_q.halted         <= halt_q;
          res_q.halt_code      <= halt_q ? halt_val_q : 32'd0;
          res_q.divide_by_zero <= dz_q;
          res_q.bad_opcode     <= bad_q;
          res_valid_q          <= 1'b1;
          pc_q                 <= next_q;
          state_q              <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

FILE: hw/rtl/predicated_byte_cpu_execute_top.sv
// ----------------------------------------------------------------------------
// predicated_byte_cpu_execute_top
// Executes one packed instruction word per input transaction against a byte
// register file and a byte data memory, returning one result transaction.
// ----------------------------------------------------------------------------
//  Channel   Direction  Payload
//  s_axis    in         instruction word (57 bits in tdata)
//  m_axis    out        next pc, print, halt and fault flags (76 bits in tdata)
//  cfg       in         fault reason byte, write only
//
// Sequence: dequeue, six register reads for predicate and operands, execute,
// result; divide/modulo, push, load, pop and two-destination ALU ops add
// states of their own, while a false predicate or a halted block ends early.
// Reset: a clearing pass over all 2**MemAddrBits addresses (4096 by default)
// zeroes data memory and register file; no instruction is accepted meanwhile.
// Stalls: a two-entry queue keeps accepting words until full while a result
// waits; the next instruction is dequeued in the cycle after that result is taken.
module predicated_byte_cpu_execute_top #(
  parameter int unsigned MemAddrBits = pbc_pkg::MEM_ADDR_BITS
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // tdata: instruction_word [56:0], zero fill above
  input  logic [pbc_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // tdata: next_pc, print_valid, print_char, halted, halt_code,
  //        divide_by_zero, bad_opcode, zero fill above
  output logic [pbc_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  input  logic                               cfg_we_i,
  input  logic [7:0]                         cfg_wdata_i
);
  import pbc_pkg::*;

  pbc_item_t   head;
  logic        head_valid, pop, clearing;
  pbc_result_t res;
  logic [7:0]  fault_reason_q;

  // Hold the fault reason byte; the user must write it only while idle, the block does not enforce this.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fault_reason_q <= '0;
    end else if (cfg_we_i) begin
      fault_reason_q <= cfg_wdata_i;
    end
  end

  pbc_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .block_i       (clearing),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .head_o        (head),
    .head_valid_o  (head_valid),
    .pop_i         (pop)
  );

  pbc_exec #(
    .MemAddrBits (MemAddrBits)
  ) u_exec (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_i         (head),
    .item_valid_i   (head_valid),
    .item_pop_o     (pop),
    .clearing_o     (clearing),
    .fault_reason_i (fault_reason_q),
    .res_o          (res),
    .res_valid_o    (m_axis_tvalid),
    .res_ready_i    (m_axis_tready)
  );

  // Pack result fields from next_pc upward, zero fill to whole bytes.
  assign m_axis_tdata = OUT_TDATA_W'(res);

endmodule
